// ----- rtl/wcra_pkg.sv -----
`timescale 1ns / 1ps
package wcra_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int COORD_BITS_DEF = 10;
  localparam int RADIUS_BITS    = 9;
  localparam int WIN_W          = 5;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd15;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [0:0] REG_WINDOW = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_LOAD
  } wcra_state_e;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic div_load;
    logic div_step;
    logic load;
  } wcra_cmd_t;

  typedef struct packed {
    logic rd_pending;
    logic sum_done;
    logic div_done;
    logic out_free;
  } wcra_sts_t;

endpackage

// ----- rtl/wcra_ctrl.sv -----
`timescale 1ns / 1ps
module wcra_ctrl
  import wcra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  wcra_sts_t sts_i,
  output logic      in_ready_o,
  output wcra_cmd_t cmd_o
);

  wcra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sts_i.sum_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_SUM: begin
        cmd_o.rd_issue = sts_i.rd_pending;
        cmd_o.div_load = sts_i.sum_done;
      end
      ST_DIV: begin
        cmd_o.div_step = !sts_i.div_done;
      end
      ST_LOAD: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- rtl/wcra_dp.sv -----
`timescale 1ns / 1ps
module wcra_dp
  import wcra_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wcra_cmd_t              cmd_i,
  output wcra_sts_t              sts_o,
  input  logic [WIN_W-1:0]       window_i,
  input  logic [COORD_BITS-1:0]  center_x_i,
  input  logic [COORD_BITS-1:0]  center_y_i,
  input  logic [RADIUS_BITS-1:0] circle_radius_i,
  input  logic                   m_ready_i,
  output logic                   m_valid_o,
  output logic [COORD_BITS-1:0]  mean_x_o,
  output logic [COORD_BITS-1:0]  mean_y_o,
  output logic [RADIUS_BITS-1:0] mean_radius_o
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int LANE_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int SUM_W  = LANE_W + CNT_W;
  localparam int ENT_W  = 2 * COORD_BITS + RADIUS_BITS;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  logic [ENT_W-1:0] mem_q [MAX_WINDOW];
  logic [ENT_W-1:0] rdata_q;

  logic [PTR_W-1:0]  wptr_q, rd_addr_q;
  logic [CNT_W-1:0]  seen_q, seen_new, count_q, count_d, rd_cnt_q;
  logic              acc_vld_q, m_valid_q;
  logic [SUM_W-1:0]  sum_q [3];
  logic [SUM_W-1:0]  quo_q [3];
  logic [CNT_W-1:0]  rem_q [3];
  logic [SUM_W-1:0]  quo_d [3];
  logic [CNT_W-1:0]  rem_d [3];
  logic [DCNT_W-1:0] div_cnt_q;
  logic [CMP_W-1:0]  win_ext, span, seen_ext, cnt_sel;
  logic              count_zero;

  assign seen_new = (seen_q < CNT_W'(MAX_WINDOW)) ? seen_q + 1'b1 : seen_q;

  always_comb begin
    win_ext  = CMP_W'(window_i);
    span     = (win_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : win_ext;
    seen_ext = CMP_W'(seen_new);
    cnt_sel  = (span < seen_ext) ? span : seen_ext;
    count_d  = CNT_W'(cnt_sel);
  end

  assign count_zero = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[wptr_q] <= {circle_radius_i, center_y_i, center_x_i};
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q    <= '0;
      seen_q    <= '0;
      count_q   <= '0;
      rd_cnt_q  <= '0;
      rd_addr_q <= '0;
      acc_vld_q <= 1'b0;
      div_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.rd_issue;
      if (cmd_i.accept) begin
        wptr_q    <= (wptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wptr_q + 1'b1;
        seen_q    <= seen_new;
        count_q   <= count_d;
        rd_cnt_q  <= '0;
        rd_addr_q <= wptr_q;
      end
      if (cmd_i.rd_issue) begin
        rd_cnt_q  <= rd_cnt_q + 1'b1;
        rd_addr_q <= (rd_addr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_addr_q - 1'b1;
      end
      if (cmd_i.div_load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    logic [CNT_W:0] trial;
    logic           ge;
    for (int l = 0; l < 3; l++) begin
      trial    = {rem_q[l], quo_q[l][SUM_W-1]};
      ge       = (trial >= {1'b0, count_q});
      rem_d[l] = ge ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
      quo_d[l] = {quo_q[l][SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int l = 0; l < 3; l++) sum_q[l] <= '0;
    end else if (acc_vld_q) begin
      sum_q[0] <= sum_q[0] + SUM_W'(rdata_q[COORD_BITS-1:0]);
      sum_q[1] <= sum_q[1] + SUM_W'(rdata_q[2*COORD_BITS-1:COORD_BITS]);
      sum_q[2] <= sum_q[2] + SUM_W'(rdata_q[ENT_W-1:2*COORD_BITS]);
    end
    if (cmd_i.div_load) begin
      for (int l = 0; l < 3; l++) begin
        quo_q[l] <= sum_q[l];
        rem_q[l] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < 3; l++) begin
        quo_q[l] <= quo_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
    if (cmd_i.load) begin
      mean_x_o      <= count_zero ? '0 : quo_q[0][COORD_BITS-1:0];
      mean_y_o      <= count_zero ? '0 : quo_q[1][COORD_BITS-1:0];
      mean_radius_o <= count_zero ? '0 : quo_q[2][RADIUS_BITS-1:0];
    end
  end

  assign sts_o.rd_pending = (rd_cnt_q != count_q);
  assign sts_o.sum_done   = (rd_cnt_q == count_q) && !acc_vld_q;
  assign sts_o.div_done   = (div_cnt_q == DCNT_W'(SUM_W));
  assign sts_o.out_free   = !m_valid_q || m_ready_i;
  assign m_valid_o        = m_valid_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(MAX_WINDOW)) && (count_q <= seen_q))
    else $error("averaging count exceeds stored entries");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (rd_cnt_q != count_q))
    else $error("history read past averaging count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!m_valid_q || m_ready_i))
    else $error("result overwritten while still pending");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> m_valid_q)
    else $error("loaded result not presented");

endmodule

// ----- rtl/windowed_center_radius_average_core.sv -----
`timescale 1ns / 1ps
// Windowed mean of detected circles.
// Input stream: one item per detected circle, tdata holds center_x, center_y
// and circle_radius. Output stream: one item per input with the truncated
// means over the last window_length entries (or all entries seen while fewer
// have arrived). Window zero yields all-zero means; windows above MAX_WINDOW
// are clamped.
// APB register 0 (byte address 0): window_length, 5 bits, reset 15.
// Flow: the item is accepted, the history is summed through the single memory
// read port, the sums are divided by the count in three radix-2 divider lanes
// that share one step counter (SUM_W = max(COORD_BITS, 9) +
// clog2(MAX_WINDOW+1), 15 at defaults), and the quotients are loaded into the
// output register. One item is in work at a time and the next is accepted in
// the cycle the result appears.
// Reset clears the pointers, the entry count and the output valid; history
// memory needs no clear since only written entries are read.
// When the receiver stalls, the result is held in the output register while
// the next item is accepted and worked; that item waits before loading.
module windowed_center_radius_average_core
  import wcra_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // center_x, center_y, circle_radius, zero padding
  input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // mean_x, mean_y, mean_radius, zero padding
  output logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int FLD_W   = 2 * COORD_BITS + RADIUS_BITS;
  localparam int TDATA_W = ((FLD_W + 7) / 8) * 8;

  logic [WIN_W-1:0]       window_q;
  wcra_cmd_t              cmd;
  wcra_sts_t              sts;
  logic [COORD_BITS-1:0]  mean_x, mean_y;
  logic [RADIUS_BITS-1:0] mean_radius;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW)) begin
      window_q <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW) ? PDATA_W'(window_q) : '0;

  wcra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  wcra_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .window_i        (window_q),
    .center_x_i      (s_axis_tdata[COORD_BITS-1:0]),
    .center_y_i      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .circle_radius_i (s_axis_tdata[FLD_W-1:2*COORD_BITS]),
    .m_ready_i       (m_axis_tready),
    .m_valid_o       (m_axis_tvalid),
    .mean_x_o        (mean_x),
    .mean_y_o        (mean_y),
    .mean_radius_o   (mean_radius)
  );

  assign m_axis_tdata = TDATA_W'({mean_radius, mean_y, mean_x});

endmodule
